[hdl/lcw_pkg.sv]
// shared types, codes and constant tables for the character display writer
`timescale 1ns / 1ps
package lcw_pkg;

  localparam int DEF_LINE_WIDTH = 16;
  localparam int DEF_LINE_COUNT = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int NUM_DIGITS     = 5;
  localparam int SEQ_LEN        = 10;

  localparam logic [2:0] OP_TEXT   = 3'd0;
  localparam logic [2:0] OP_RAW    = 3'd1;
  localparam logic [2:0] OP_NUMBER = 3'd2;
  localparam logic [2:0] OP_MOVE   = 3'd3;
  localparam logic [2:0] OP_BACK   = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;
  localparam logic [2:0] OP_INIT   = 3'd6;

  localparam logic [7:0] NEWLINE    = 8'd10;
  localparam logic [7:0] ADDR_LINE0 = 8'h80;
  localparam logic [7:0] ADDR_LINE1 = 8'hC0;
  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [6:0] COL_MAX    = 7'd127;
  localparam logic [7:0] NUM_STEP   = 8'd5;

  // init sequence followed by the clear sequence
  localparam logic [7:0] SEQ_BYTES [SEQ_LEN] = '{
    8'h33, 8'h32, 8'h28, 8'h08, 8'h0E, 8'h01, 8'h06, 8'h02,
    8'h01, 8'h02
  };
  localparam logic [3:0] SEQ_INIT_BASE  = 4'd0;
  localparam logic [2:0] SEQ_INIT_LAST  = 3'd7;
  localparam logic [3:0] SEQ_CLEAR_BASE = 4'd8;
  localparam logic [2:0] SEQ_CLEAR_LAST = 3'd1;

  localparam logic [16:0] POW10 [NUM_DIGITS] = '{
    17'd10000, 17'd1000, 17'd100, 17'd10, 17'd1
  };

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  char_code;
    logic [15:0] number_value;
    logic [6:0]  target_column;
    logic [1:0]  target_row;
    logic [6:0]  back_amount;
  } cmd_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       is_data;
    logic       last;
  } wr_t;

  typedef enum logic [1:0] {
    JOB_BYTE   = 2'd0,
    JOB_SEQ    = 2'd1,
    JOB_NUMBER = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        is_data;
    logic [7:0]  byte_val;
    logic [3:0]  seq_base;
    logic [2:0]  seq_last;
    logic [15:0] number_value;
  } job_t;

  function automatic logic [7:0] addr_byte(input logic line, input logic [6:0] col);
    logic [7:0] base;
    base = line ? ADDR_LINE1 : ADDR_LINE0;
    return base + {1'b0, col};
  endfunction

endpackage

[hdl/lcw_front.sv]
// command front end: cursor tracking and job classification
`timescale 1ns / 1ps
module lcw_front #(
  parameter int LINE_WIDTH = lcw_pkg::DEF_LINE_WIDTH,
  parameter int LINE_COUNT = lcw_pkg::DEF_LINE_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  input  lcw_pkg::cmd_t cmd,
  input  logic          accept,
  output logic          push,
  output lcw_pkg::job_t job
);
  import lcw_pkg::*;

  logic [6:0] col, col_next;
  logic       line, line_next;
  logic       emit;
  logic [7:0] num_sum;

  assign num_sum = {1'b0, col} + NUM_STEP;
  assign push    = accept && emit;

  always_comb begin
    col_next = col;
    line_next = line;
    emit = 1'b0;
    job = '0;
    job.kind = JOB_BYTE;
    job.number_value = cmd.number_value;
    unique case (cmd.op)
      OP_TEXT, OP_RAW: begin
        if (cmd.op == OP_TEXT && cmd.char_code == NEWLINE) begin
          line_next = (LINE_COUNT > 1) ? ~line : 1'b0;
          col_next = '0;
          emit = 1'b1;
          job.byte_val = addr_byte(line_next, 7'd0);
        end else if (col < 7'(LINE_WIDTH)) begin
          col_next = col + 7'd1;
          emit = 1'b1;
          job.is_data = 1'b1;
          job.byte_val = cmd.char_code;
        end
      end
      OP_NUMBER: begin
        col_next = num_sum[7] ? COL_MAX : num_sum[6:0];
        emit = 1'b1;
        job.kind = JOB_NUMBER;
        job.is_data = 1'b1;
      end
      OP_MOVE: begin
        if (cmd.target_row < 2'(LINE_COUNT) && cmd.target_column < 7'(LINE_WIDTH)) begin
          col_next = cmd.target_column;
          line_next = (cmd.target_row != 2'd0);
          emit = 1'b1;
          job.byte_val = addr_byte(line_next, cmd.target_column);
        end
      end
      OP_BACK: begin
        if (cmd.back_amount != 7'd0 && cmd.back_amount <= col) begin
          col_next = col - cmd.back_amount;
          emit = 1'b1;
          job.byte_val = addr_byte(line, col_next);
        end
      end
      OP_CLEAR: begin
        col_next = '0;
        line_next = 1'b0;
        emit = 1'b1;
        job.kind = JOB_SEQ;
        job.seq_base = SEQ_CLEAR_BASE;
        job.seq_last = SEQ_CLEAR_LAST;
      end
      OP_INIT: begin
        emit = 1'b1;
        job.kind = JOB_SEQ;
        job.seq_base = SEQ_INIT_BASE;
        job.seq_last = SEQ_INIT_LAST;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      line <= 1'b0;
    end else if (accept) begin
      col <= col_next;
      line <= line_next;
    end
  end

endmodule

[hdl/lcw_queue.sv]
// small job queue between the front end and the nibble sequencer
`timescale 1ns / 1ps
module lcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lcw_pkg::job_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output lcw_pkg::job_t rdata
);
  import lcw_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      priority if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hdl/lcw_back.sv]
// nibble sequencer: expands queued jobs into registered nibble writes
`timescale 1ns / 1ps
module lcw_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  lcw_pkg::job_t head,
  output logic          pop,
  output logic          wr_valid,
  input  logic          wr_stall,
  output lcw_pkg::wr_t  wr
);
  import lcw_pkg::*;

  logic        phase;
  logic [2:0]  idx;
  logic [15:0] rem;
  logic [3:0]  digit;
  logic        load;
  logic        last_nib;
  logic [3:0]  nib;
  logic [7:0]  byte_cur;
  logic [3:0]  seq_idx;
  logic [15:0] r_cur;
  logic [16:0] th [10];
  logic [3:0]  d;
  logic [15:0] rem_next;

  assign load    = q_valid && (!wr_valid || !wr_stall);
  assign pop     = load && last_nib;
  assign seq_idx = head.seq_base + {1'b0, idx};
  assign r_cur   = (idx == 3'd0) ? head.number_value : rem;

  // decimal digit by comparing against the multiples of the place value
  always_comb begin
    for (int k = 0; k < 10; k++) begin
      th[k] = POW10[idx] * 17'(k);
    end
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({1'b0, r_cur} >= th[k]) begin
        d = 4'(k);
      end
    end
    rem_next = 16'({1'b0, r_cur} - th[d]);
  end

  always_comb begin
    byte_cur = head.byte_val;
    last_nib = phase;
    unique case (head.kind)
      JOB_BYTE: begin
        byte_cur = head.byte_val;
        last_nib = phase;
      end
      JOB_SEQ: begin
        byte_cur = SEQ_BYTES[seq_idx];
        last_nib = phase && (idx == head.seq_last);
      end
      JOB_NUMBER: begin
        byte_cur = {ASCII_ZERO[7:4], digit};
        last_nib = phase && (idx == 3'(NUM_DIGITS - 1));
      end
      default: begin
        byte_cur = head.byte_val;
        last_nib = phase;
      end
    endcase
    nib = phase ? byte_cur[3:0] : byte_cur[7:4];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
      phase <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        wr_valid <= 1'b1;
        if (last_nib) begin
          phase <= 1'b0;
          idx <= '0;
        end else if (phase) begin
          phase <= 1'b0;
          idx <= idx + 3'd1;
        end else begin
          phase <= 1'b1;
        end
      end else if (!wr_stall) begin
        wr_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr.nibble <= nib;
      wr.is_data <= head.is_data;
      wr.last <= last_nib;
    end
    if (load && !phase) begin
      rem <= rem_next;
      digit <= d;
    end
  end

  a_phase_out: assert property (@(posedge clk) disable iff (rst)
    phase |-> wr_valid)
    else $error("low nibble pending without a held high nibble");

  a_job_held: assert property (@(posedge clk) disable iff (rst)
    (idx != 3'd0 || phase) |-> q_valid)
    else $error("job in progress left the queue");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (load && phase && head.kind == JOB_NUMBER) |-> (digit <= 4'd9))
    else $error("decimal digit out of range");

endmodule

[hdl/char_lcd_cursor_writer.sv]
// top level of the two-line character display nibble writer
`timescale 1ns / 1ps
// usage:
//   cmd channel (cmd_valid, cmd_stall, cmd) takes one command per transaction;
//   a transaction completes when cmd_valid is high and cmd_stall is low.
//   wr channel (wr_valid, wr_stall, wr) gives one 4-bit write per transaction,
//   high nibble of each byte first, with is_data as register select and last
//   on the final nibble of a command. commands with no effect give nothing.
//   with an idle sequencer the first nibble of a command passes through the
//   job queue and then the wr output register before it is valid. the
//   sequencer gives one nibble per cycle while wr_stall is low, so a
//   character or cursor command gives 2 nibbles, clear 4, a number 10 and
//   init 16; the front end takes a command every cycle while the four-entry
//   job queue has room, so cmd_stall rises only when that queue is full.
//   when wr_stall is high the current nibble holds on wr and the sequencer
//   waits; the queue keeps taking commands until it fills.
//   reset (rst, synchronous) sets cursor column and line to 0, empties the
//   queue and drops any nibble in flight.
module char_lcd_cursor_writer #(
  parameter int LINE_WIDTH = lcw_pkg::DEF_LINE_WIDTH,
  parameter int LINE_COUNT = lcw_pkg::DEF_LINE_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  lcw_pkg::cmd_t cmd,
  output logic          wr_valid,
  input  logic          wr_stall,
  output lcw_pkg::wr_t  wr
);
  import lcw_pkg::*;

  logic accept;
  logic push;
  logic full;
  logic pop;
  logic q_valid;
  job_t job_in;
  job_t job_head;

  assign cmd_stall = full;
  assign accept    = cmd_valid && !full;

  lcw_front #(
    .LINE_WIDTH(LINE_WIDTH),
    .LINE_COUNT(LINE_COUNT)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .accept (accept),
    .push   (push),
    .job    (job_in)
  );

  lcw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (pop),
    .valid (q_valid),
    .rdata (job_head)
  );

  lcw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (job_head),
    .pop      (pop),
    .wr_valid (wr_valid),
    .wr_stall (wr_stall),
    .wr       (wr)
  );

endmodule
